// ----- rtl/core/fixed_record_table_lookup_defines.svh -----
// Assertion macros used by the record table controller.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef FIXED_RECORD_TABLE_LOOKUP_DEFINES_SVH
`define FIXED_RECORD_TABLE_LOOKUP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRTL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frtl: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FRTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frtl: next-cycle check failed");

`endif

// ----- rtl/core/frtl_pkg.sv -----
// Package for the record table: field widths, codes, record and command types.
// No dependencies; used by the interfaces and every module of the block.
`default_nettype none

package frtl_pkg;

    localparam int unsigned FUNC_W     = 2;
    localparam int unsigned HEAD_W     = 64;
    localparam int unsigned TAIL_W     = 8;
    localparam int unsigned AGE_W      = 8;
    localparam int unsigned HEIGHT_W   = 9;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned INDEX_W    = 4;
    localparam int unsigned NAME_BYTES = HEAD_W / 8;

    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 9'd300;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_FIND   = 2'd2,
        FUNC_LIST   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_BAD_HEIGHT = 3'd3,
        ST_EMPTY      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SRC_NEW  = 2'd0,
        SRC_MEM  = 2'd1,
        SRC_NONE = 2'd2
    } t_out_src;

    typedef struct packed {
        logic [HEAD_W-1:0]   head;
        logic [TAIL_W-1:0]   tail;
        logic [AGE_W-1:0]    age;
        logic [HEIGHT_W-1:0] height;
    } t_record;

    typedef struct packed {
        logic     ready;
        logic     rd_next;
        logic     set_shift_ptr;
        logic     shift_wr;
        logic     mem_add;
        logic     dec;
        logic     out_load;
        t_out_src out_src;
        t_status  out_status;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic  req_valid;
        t_func req_func;
        t_func func;
        logic  full;
        logic  empty;
        logic  bad_height;
        logic  ptr_end;
        logic  rd_valid;
        logic  hit;
        logic  out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/core/frtl_req_if.sv -----
// Request channel of the record table: valid/ready handshake and request fields.
// Depends on frtl_pkg for the field widths.
`default_nettype none

interface frtl_req_if;
    logic                             valid;
    logic                             ready;
    logic [frtl_pkg::FUNC_W-1:0]      func;
    logic [frtl_pkg::HEAD_W-1:0]      name_head;
    logic [frtl_pkg::TAIL_W-1:0]      name_tail;
    logic [frtl_pkg::AGE_W-1:0]       age_in;
    logic [frtl_pkg::HEIGHT_W-1:0]    height_in;

    modport source (
        output valid, func, name_head, name_tail, age_in, height_in,
        input  ready
    );
    modport sink (
        input  valid, func, name_head, name_tail, age_in, height_in,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/frtl_rsp_if.sv -----
// Response channel of the record table: valid/ready handshake and result fields.
// Depends on frtl_pkg for the field widths.
`default_nettype none

interface frtl_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [frtl_pkg::STATUS_W-1:0]    status;
    logic [frtl_pkg::INDEX_W-1:0]     entry_index;
    logic [frtl_pkg::HEAD_W-1:0]      name_head_out;
    logic [frtl_pkg::TAIL_W-1:0]      name_tail_out;
    logic [frtl_pkg::AGE_W-1:0]       age_out;
    logic [frtl_pkg::HEIGHT_W-1:0]    height_out;
    logic                             last;

    modport source (
        output valid, status, entry_index, name_head_out, name_tail_out,
               age_out, height_out, last,
        input  ready
    );
    modport sink (
        input  valid, status, entry_index, name_head_out, name_tail_out,
               age_out, height_out, last,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/frtl_datapath.sv -----
// Record table datapath: request capture, record memory, scan pointer and output register.
// Depends on frtl_pkg and the frtl_req_if / frtl_rsp_if interfaces.
`default_nettype none

module frtl_datapath #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    frtl_req_if.sink               i_req,
    frtl_rsp_if.source             o_rsp,
    input  frtl_pkg::t_dp_cmd      i_cmd,
    output frtl_pkg::t_dp_stat     o_stat
);

    localparam int unsigned IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
    localparam int unsigned OUT_IDX_W = frtl_pkg::INDEX_W;

    frtl_pkg::t_record r_mem [CAPACITY];

    logic [frtl_pkg::HEAD_W-1:0]   head_norm;
    logic [frtl_pkg::TAIL_W-1:0]   tail_norm;
    logic                          keep;

    frtl_pkg::t_record             r_key;
    frtl_pkg::t_func               r_func;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              r_ptr;
    frtl_pkg::t_record             r_rd_data;
    logic [IDX_W-1:0]              r_chk_idx;
    logic                          r_rd_valid;

    logic                          accept;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    frtl_pkg::t_record             wr_data;

    logic                          r_out_valid;
    frtl_pkg::t_record             r_out_rec;
    frtl_pkg::t_status             r_out_status;
    logic [OUT_IDX_W-1:0]          r_out_idx;
    logic                          r_out_last;
    frtl_pkg::t_record             n_out_rec;
    logic [OUT_IDX_W-1:0]          n_out_idx;
    logic                          out_free;

    assign i_req.ready = i_cmd.ready;
    assign accept      = i_req.valid & i_cmd.ready;

    // A name ends at its first zero byte; everything after it reads as zero.
    always_comb begin
        keep = 1'b1;
        for (int b = 0; b < frtl_pkg::NAME_BYTES; b++) begin
            if (i_req.name_head[8*b +: 8] == 8'd0) begin
                keep = 1'b0;
            end
            head_norm[8*b +: 8] = keep ? i_req.name_head[8*b +: 8] : 8'd0;
        end
        tail_norm = keep ? i_req.name_tail : '0;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key.head   <= head_norm;
            r_key.tail   <= tail_norm;
            r_key.age    <= i_req.age_in;
            r_key.height <= i_req.height_in;
            r_func       <= frtl_pkg::t_func'(i_req.func);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.mem_add) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.dec) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ptr <= '0;
        end else if (i_cmd.set_shift_ptr) begin
            r_ptr <= CNT_W'(r_chk_idx) + CNT_W'(1);
        end else if (i_cmd.rd_next) begin
            r_ptr <= r_ptr + CNT_W'(1);
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IDX_W-1:0];
        wr_data = r_key;
        if (i_cmd.mem_add) begin
            wr_en = 1'b1;
        end else if (i_cmd.shift_wr && r_rd_valid) begin
            wr_en   = 1'b1;
            wr_addr = r_chk_idx - IDX_W'(1);
            wr_data = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_next) begin
            r_rd_data <= r_mem[r_ptr[IDX_W-1:0]];
            r_chk_idx <= r_ptr[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.rd_next;
        end
    end

    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_out_rec = '0;
        n_out_idx = '0;
        case (i_cmd.out_src)
            frtl_pkg::SRC_NEW: begin
                n_out_rec = r_key;
                n_out_idx = OUT_IDX_W'(r_count);
            end
            frtl_pkg::SRC_MEM: begin
                n_out_rec = r_rd_data;
                n_out_idx = OUT_IDX_W'(r_chk_idx);
            end
            default: begin
                n_out_rec = '0;
                n_out_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_rec    <= n_out_rec;
            r_out_idx    <= n_out_idx;
            r_out_status <= i_cmd.out_status;
            r_out_last   <= i_cmd.out_last;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.entry_index   = r_out_idx;
    assign o_rsp.name_head_out = r_out_rec.head;
    assign o_rsp.name_tail_out = r_out_rec.tail;
    assign o_rsp.age_out       = r_out_rec.age;
    assign o_rsp.height_out    = r_out_rec.height;
    assign o_rsp.last          = r_out_last;

    assign o_stat.req_valid  = i_req.valid;
    assign o_stat.req_func   = frtl_pkg::t_func'(i_req.func);
    assign o_stat.func       = r_func;
    assign o_stat.full       = (r_count == CNT_W'(CAPACITY));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.bad_height = (r_key.height > frtl_pkg::MAX_HEIGHT);
    assign o_stat.ptr_end    = (r_ptr == r_count);
    assign o_stat.rd_valid   = r_rd_valid;
    assign o_stat.hit        = r_rd_valid && (r_rd_data.head == r_key.head)
                               && (r_rd_data.tail == r_key.tail);
    assign o_stat.out_free   = out_free;

endmodule

`default_nettype wire

// ----- rtl/core/frtl_ctrl.sv -----
// Record table controller: sequences add, scan, shift and list over the datapath.
// Depends on frtl_pkg and fixed_record_table_lookup_defines.svh.
`default_nettype none

`include "fixed_record_table_lookup_defines.svh"

module frtl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  frtl_pkg::t_dp_stat     i_stat,
    output frtl_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ADD   = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_HIT   = 8'b0000_1000,
        S_SHIFT = 8'b0001_0000,
        S_LIST  = 8'b0010_0000,
        S_LEMIT = 8'b0100_0000,
        S_MISS  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state              = r_state;
        o_cmd                = '0;
        o_cmd.out_src        = frtl_pkg::SRC_NONE;
        o_cmd.out_status     = frtl_pkg::ST_OK;
        o_cmd.out_last       = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_stat.req_valid) begin
                    unique case (i_stat.req_func)
                        frtl_pkg::FUNC_ADD: n_state = S_ADD;
                        frtl_pkg::FUNC_LIST: n_state = i_stat.empty ? S_MISS : S_LIST;
                        default: n_state = i_stat.empty ? S_MISS : S_SCAN;
                    endcase
                end
            end
            S_ADD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.full) begin
                        o_cmd.out_status = frtl_pkg::ST_FULL;
                    end else if (i_stat.bad_height) begin
                        o_cmd.out_status = frtl_pkg::ST_BAD_HEIGHT;
                    end else begin
                        o_cmd.out_src = frtl_pkg::SRC_NEW;
                        o_cmd.mem_add = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    n_state = S_HIT;
                end else if (!i_stat.ptr_end) begin
                    o_cmd.rd_next = 1'b1;
                end else if (i_stat.rd_valid) begin
                    n_state = S_MISS;
                end
            end
            S_HIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_src  = frtl_pkg::SRC_MEM;
                    if (i_stat.func == frtl_pkg::FUNC_REMOVE) begin
                        o_cmd.set_shift_ptr = 1'b1;
                        n_state             = S_SHIFT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.shift_wr = 1'b1;
                if (!i_stat.ptr_end) begin
                    o_cmd.rd_next = 1'b1;
                end else if (!i_stat.rd_valid) begin
                    o_cmd.dec = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_LIST: begin
                o_cmd.rd_next = 1'b1;
                n_state       = S_LEMIT;
            end
            S_LEMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_src  = frtl_pkg::SRC_MEM;
                    o_cmd.out_last = i_stat.ptr_end;
                    n_state        = i_stat.ptr_end ? S_IDLE : S_LIST;
                end
            end
            S_MISS: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = (i_stat.func == frtl_pkg::FUNC_LIST)
                                       ? frtl_pkg::ST_EMPTY : frtl_pkg::ST_NOT_FOUND;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `FRTL_ASSERT_SAME(a_load_needs_room, i_clk, i_rst_n, o_cmd.out_load, i_stat.out_free)
    `FRTL_ASSERT_SAME(a_add_not_full, i_clk, i_rst_n, o_cmd.mem_add, !i_stat.full)
    `FRTL_ASSERT_SAME(a_dec_not_empty, i_clk, i_rst_n, o_cmd.dec, !i_stat.empty)
    `FRTL_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, i_stat.req_valid && o_cmd.ready, !o_cmd.ready)

endmodule

`default_nettype wire

// ----- rtl/core/fixed_record_table_lookup.sv -----
// Bounded record table keyed by a name of up to nine bytes.
// Requests enter on i_req (valid/ready); results leave on o_rsp (valid/ready),
// one result per request except list, which gives one result per stored
// record in index order with last set on the final one.
// One request is handled at a time; ready is high only while the block is idle.
// Steps per request: add checks for a full table and a bad height, then
//   writes the record; find reads the records in index order until a name
//   matches or all are read; remove is a find and then a shift of each later
//   record down by one index, one record per cycle; list reads and emits each
//   stored record in turn. Find, remove and list on an empty table go straight
//   to the miss result. The record memory has one read and one write port.
// A result waits in the output register while o_rsp.ready is low and the
// sequencer holds until the register frees.
// Reset empties the table at once; record contents are not cleared.
// Depends on frtl_pkg, frtl_req_if, frtl_rsp_if, frtl_ctrl and frtl_datapath.
`default_nettype none

module fixed_record_table_lookup #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    frtl_req_if.sink    i_req,
    frtl_rsp_if.source  o_rsp
);

    frtl_pkg::t_dp_cmd  cmd;
    frtl_pkg::t_dp_stat stat;

    frtl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    frtl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

`default_nettype wire
